>>> src/lxy_pkg.sv
// Shared types, constants and the quarter-wave cosine table for the lattice XY gauge energy
// block. Used by lxy_cos and by the top level; the generic RAM does not depend on it.
`default_nettype none

package lxy_pkg;

   // Field and register widths
   localparam int PhaseBits  = 16;
   localparam int EnergyBits = 32;
   localparam int CfgBits    = 9;
   localparam int CsrIdxBits = 1;

   // Lattice side limits
   localparam int MaxSide  = 256;
   localparam int SideBits = $clog2(MaxSide);
   localparam int MinSide  = 2;

   // Register indexes
   localparam logic [CsrIdxBits-1:0] CsrGridHeight = 1'd0;
   localparam logic [CsrIdxBits-1:0] CsrGridWidth  = 1'd1;

   // Register reset values
   localparam logic [CfgBits-1:0] GridSideReset = 9'd16;

   // Cosine table geometry: full table of CosDepth entries over one turn,
   // stored as a quarter wave of QuarterDepth entries
   localparam int CosDepth     = 1024;
   localparam int CosIdxBits   = $clog2(CosDepth);
   localparam int QuarterDepth = CosDepth / 4 + 1;
   localparam int QuarterBits  = $clog2(QuarterDepth);
   localparam int CosBits      = 16;
   localparam int CosRoundBit  = PhaseBits - CosIdxBits - 1;

   // Angle offset scale: 2^32 / (2 pi), rounded
   localparam logic [63:0] TurnInvQ32 = 64'd683565276;
   localparam logic [63:0] TwoPiQ28   = 64'd1686629713;
   localparam logic [63:0] OneQ28     = 64'd268435456;

   typedef logic signed [CosBits-1:0] cos_type;
   typedef cos_type quarter_table_type [QuarterDepth];

   // Pipeline tag carried beside each site
   typedef struct packed {
      logic valid;
      logic has_h;
      logic has_v;
      logic last;
   } tag_type;

   // cos(pi * 2j / CosDepth) in Q1.14, Taylor series in Q.28 with twelve terms
   function automatic cos_type quarter_cos(input logic [QuarterBits-1:0] j);
      logic [63:0]        num;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      num  = {{(63-QuarterBits){1'b0}}, j, 1'b0};
      x    = (TwoPiQ28 * num + 64'(CosDepth)) / 64'(2 * CosDepth);
      x2   = (x * x + 64'd134217728) >> 28;
      term = OneQ28;
      sum  = $signed(OneQ28);
      term = term * x2 / 64'd2;   sum = sum - $signed(term);
      term = term * x2 / 64'd12;  sum = sum + $signed(term);
      term = term * x2 / 64'd30;  sum = sum - $signed(term);
      term = term * x2 / 64'd56;  sum = sum + $signed(term);
      term = term * x2 / 64'd90;  sum = sum - $signed(term);
      term = term * x2 / 64'd132; sum = sum + $signed(term);
      term = term * x2 / 64'd182; sum = sum - $signed(term);
      term = term * x2 / 64'd240; sum = sum + $signed(term);
      term = term * x2 / 64'd306; sum = sum - $signed(term);
      term = term * x2 / 64'd380; sum = sum + $signed(term);
      term = term * x2 / 64'd462; sum = sum - $signed(term);
      term = term * x2 / 64'd552; sum = sum + $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      r = ($unsigned(sum) + 64'd8192) >> 14;
      return $signed(r[CosBits-1:0]);
   endfunction

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type t;
      for (int j = 0; j < QuarterDepth; j++) begin
         t[j] = quarter_cos(QuarterBits'(j));
      end
      return t;
   endfunction

   localparam quarter_table_type QuarterCos = build_quarter_table();

   // Last row or column index for a size register, with the size clamped to range
   function automatic logic [SideBits-1:0] side_last(input logic [CfgBits-1:0] v);
      logic [CfgBits-1:0] s;
      if (v < CfgBits'(MinSide)) begin
         s = CfgBits'(MinSide);
      end else if (v > CfgBits'(MaxSide)) begin
         s = CfgBits'(MaxSide);
      end else begin
         s = v;
      end
      s = s - CfgBits'(1);
      return s[SideBits-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/lxy_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read-first: a read and a write to one address in a cycle return the old data.
`default_nettype none

module lxy_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/lxy_cos.sv
// Two-stage bond cosine unit: angle to table index and quarter-wave fold, then lookup.
// Depends on lxy_pkg for the quarter-wave table and widths.
`default_nettype none

module lxy_cos (
   input  wire logic                              clock,
   input  wire logic                              advance,
   input  wire logic [lxy_pkg::PhaseBits-1:0]     angle_h,
   input  wire logic [lxy_pkg::PhaseBits-1:0]     angle_v,
   output lxy_pkg::cos_type                       cos_h,
   output lxy_pkg::cos_type                       cos_v
);
   import lxy_pkg::*;

   typedef struct packed {
      logic                   neg;
      logic [QuarterBits-1:0] index;
   } fold_type;

   localparam logic [CosIdxBits:0] HalfTurn    = (CosIdxBits+1)'(CosDepth / 2);
   localparam logic [CosIdxBits:0] QuarterTurn = (CosIdxBits+1)'(CosDepth / 4);
   localparam logic [CosIdxBits:0] FullTurn    = (CosIdxBits+1)'(CosDepth);
   localparam logic [PhaseBits-1:0] IdxRound   = PhaseBits'(1) << CosRoundBit;

   // Round an angle to the nearest table index and fold it to the first quarter
   function automatic fold_type fold_angle(input logic [PhaseBits-1:0] a);
      logic [PhaseBits-1:0]  r;
      logic [CosIdxBits:0]   i;
      logic [CosIdxBits:0]   m;
      logic [CosIdxBits:0]   q;
      fold_type              f;
      r = a + IdxRound;
      i = {1'b0, r[PhaseBits-1 -: CosIdxBits]};
      if (i <= HalfTurn) begin
         m = i;
      end else begin
         m = FullTurn - i;
      end
      f.neg = m > QuarterTurn;
      q = f.neg ? (HalfTurn - m) : m;
      f.index = q[QuarterBits-1:0];
      return f;
   endfunction

   fold_type fold_h_ff;
   fold_type fold_v_ff;
   cos_type  cos_h_ff;
   cos_type  cos_v_ff;
   cos_type  cos_h_in;
   cos_type  cos_v_in;

   // Look up and restore the sign of the fold
   always_comb begin
      cos_h_in = fold_h_ff.neg ? -QuarterCos[fold_h_ff.index] : QuarterCos[fold_h_ff.index];
      cos_v_in = fold_v_ff.neg ? -QuarterCos[fold_v_ff.index] : QuarterCos[fold_v_ff.index];
   end

   // Advance both stages together with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         fold_h_ff <= fold_angle(angle_h);
         fold_v_ff <= fold_angle(angle_v);
         cos_h_ff  <= cos_h_in;
         cos_v_ff  <= cos_v_in;
      end
   end

   assign cos_h = cos_h_ff;
   assign cos_v = cos_v_ff;

endmodule

`default_nettype wire

>>> src/lattice_xy_gauge_energy.sv
// Top level of the lattice XY gauge energy block: raster phase stream in, total energy out.
// Depends on lxy_pkg, lxy_ram (row line store) and lxy_cos (bond cosine unit).
`default_nettype none

// The block takes one site phase per clock in raster order while req_tready is high and,
// after the last site of the grid, sends the total energy of all bonds as one response.
// The line store holding the row above is one RAM with a registered read port, read and
// written at the site's column on the same cycle, and the path through offset multiply,
// angle sums, cosine fold, table lookup and accumulate is five registers deep. The
// finished total sits in an output register: requests keep flowing while it waits, and
// req_tready drops only when the next frame's last site reaches the accumulator before
// that total is taken. Grid height and width must be written through the csr port while
// the block is idle; the block itself does not enforce this. Values outside 2..256 act
// as the nearest limit.
module lattice_xy_gauge_energy (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request: phase in [15:0]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [lxy_pkg::PhaseBits-1:0]      req_tdata,
   // Response: energy in [31:0]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [lxy_pkg::EnergyBits-1:0]          rsp_tdata,
   // Register writes
   input  wire logic                               csr_wr_en,
   input  wire logic [lxy_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [lxy_pkg::CfgBits-1:0]        csr_wdata
);
   import lxy_pkg::*;

   // Angle offset for a row or column index: n * 2^32/(2 pi), rounded to PhaseBits bits
   function automatic logic [PhaseBits-1:0] offset_angle(input logic [SideBits-1:0] n);
      logic [SideBits+29:0] prod;
      logic [31:0]          rnd;
      prod = (SideBits+30)'(n) * TurnInvQ32[SideBits+29:0];
      rnd  = prod[31:0] + 32'd32768;
      return rnd[31:16];
   endfunction

   logic [CfgBits-1:0]    grid_height_ff;
   logic [CfgBits-1:0]    grid_width_ff;
   logic [SideBits-1:0]   col_ff,  col_in;
   logic [SideBits-1:0]   row_ff,  row_in;
   logic [PhaseBits-1:0]  left_ff;
   logic [EnergyBits-1:0] sum_ff,  sum_in;

   logic                  adv;
   logic                  req_accept;
   logic                  last_col;
   logic                  last_row;
   tag_type               s0_tag;

   tag_type               s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic [PhaseBits-1:0]  s1_here_ff, s1_left_ff;
   logic [SideBits-1:0]   s1_row_ff,  s1_col_ff;
   logic [PhaseBits-1:0]  s2_here_ff, s2_left_ff, s2_up_ff, s2_offr_ff, s2_offc_ff;
   logic [PhaseBits-1:0]  up_phase;
   logic [PhaseBits-1:0]  angle_h, angle_v;
   cos_type               cos_h, cos_v;
   logic [EnergyBits-1:0] term_h, term_v;

   logic                  rsp_valid_ff;
   logic [EnergyBits-1:0] rsp_data_ff;

   // Stall only when a new total would overwrite one not yet taken
   assign adv        = !(s4_tag_ff.valid && s4_tag_ff.last && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_height_ff <= GridSideReset;
         grid_width_ff  <= GridSideReset;
      end else if (csr_wr_en) begin
         if (csr_index == CsrGridHeight) begin
            grid_height_ff <= csr_wdata;
         end
         if (csr_index == CsrGridWidth) begin
            grid_width_ff <= csr_wdata;
         end
      end
   end

   // Raster position: advance column, wrap to next row, wrap frame
   always_comb begin
      last_col = col_ff >= side_last(grid_width_ff);
      last_row = row_ff >= side_last(grid_height_ff);
      col_in   = last_col ? '0 : col_ff + SideBits'(1);
      row_in   = row_ff;
      if (last_col) begin
         row_in = last_row ? '0 : row_ff + SideBits'(1);
      end
      s0_tag.valid = req_accept;
      s0_tag.has_h = col_ff != '0;
      s0_tag.has_v = row_ff != '0;
      s0_tag.last  = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else if (req_accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= req_tdata;
      end
   end

   // Line store: read the row above and write this site at the same column
   lxy_ram #(
      .WIDTH (PhaseBits),
      .DEPTH (MaxSide)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (up_phase)
   );

   // Pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
      end else if (adv) begin
         s1_tag_ff <= s0_tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   // Stage 1 holds the site; stage 2 adds the row above and the gauge offsets
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_here_ff <= req_tdata;
         s1_left_ff <= left_ff;
         s1_row_ff  <= row_ff;
         s1_col_ff  <= col_ff;
         s2_here_ff <= s1_here_ff;
         s2_left_ff <= s1_left_ff;
         s2_up_ff   <= up_phase;
         s2_offr_ff <= offset_angle(s1_row_ff);
         s2_offc_ff <= offset_angle(s1_col_ff);
      end
   end

   // Bond angles, wrapping modulo one turn
   assign angle_h = s2_left_ff - s2_here_ff + s2_offr_ff;
   assign angle_v = s2_up_ff - s2_here_ff - s2_offc_ff;

   lxy_cos u_cos (
      .clock   (clock),
      .advance (adv),
      .angle_h (angle_h),
      .angle_v (angle_v),
      .cos_h   (cos_h),
      .cos_v   (cos_v)
   );

   // Accumulate minus the bond cosines
   always_comb begin
      term_h = s4_tag_ff.has_h ? EnergyBits'(cos_h) : '0;
      term_v = s4_tag_ff.has_v ? EnergyBits'(cos_v) : '0;
      sum_in = sum_ff - term_h - term_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (adv && s4_tag_ff.valid) begin
         sum_ff <= s4_tag_ff.last ? '0 : sum_in;
      end
   end

   // Output register: load the total at frame end, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && s4_tag_ff.valid && s4_tag_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s4_tag_ff.valid && s4_tag_ff.last) begin
         rsp_data_ff <= sum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The last site of a frame returns the raster position to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s0_tag.last) |=> (col_ff == '0 && row_ff == '0))
      else $error("position not at origin after last site");

   // A total appears only when the last site of a frame leaves the accumulator
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(adv && s4_tag_ff.valid && s4_tag_ff.last))
      else $error("response raised without a frame end");

   // Requests are held off only while a total waits and the consumer stalls
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a pending response");

   // The accumulator restarts from zero after each frame
   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && s4_tag_ff.valid && s4_tag_ff.last) |=> (sum_ff == '0))
      else $error("energy sum not cleared at frame end");

endmodule

`default_nettype wire

>>> dv/lattice_xy_gauge_energy_tb.sv
// Self-checking bench for lattice_xy_gauge_energy: streams raster phase frames of many grid
// sizes and checks every energy total against an in-bench model of the gauge bond sums.
// Depends on lxy_pkg and the block's RTL only.

module lattice_xy_gauge_energy_tb;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 12;
   localparam int SiteTarget  = 1900;
   localparam int TableDepth  = 1024;
   localparam int SideMax     = lxy_pkg::MaxSide;

   // 2^32 / (2 pi), 2 pi in Q.28 and one in Q.28
   localparam longint unsigned RadToTurnQ32 = 64'd683565276;
   localparam longint unsigned TurnRadQ28   = 64'd1686629713;
   localparam longint unsigned UnitQ28      = 64'd268435456;

   typedef enum int {ReadyAlways, ReadyCoinFlip, ReadySparse, ReadyHold} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_tvalid = 1'b0;
   wire                                  req_tready;
   logic [lxy_pkg::PhaseBits-1:0]        req_tdata  = '0;   // phase in [15:0]
   wire                                  rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   wire  [lxy_pkg::EnergyBits-1:0]       rsp_tdata;         // energy in [31:0]
   logic                                 csr_wr_en  = 1'b0;
   logic [lxy_pkg::CsrIdxBits-1:0]       csr_index  = '0;
   logic [lxy_pkg::CfgBits-1:0]          csr_wdata  = '0;

   // Lattice model state
   logic signed [15:0] cos_rom [TableDepth];
   logic [8:0]         height_reg = lxy_pkg::GridSideReset;
   logic [8:0]         width_reg  = lxy_pkg::GridSideReset;
   logic [15:0]        line_store [SideMax];
   logic [15:0]        left_site  = '0;
   logic [31:0]        energy_acc = '0;
   int                 row_pos    = 0;
   int                 col_pos    = 0;
   int                 cols_seen  = 0;

   logic [31:0] energy_q [$];
   logic [15:0] phase_q  [$];
   logic [31:0] expected_total;
   logic [15:0] last_drawn = '0;

   int             burst_left  = 1;
   int             gap_left    = 0;
   ready_mode_type ready_mode  = ReadyAlways;
   int             ready_span  = 0;
   int             cycle_count = 0;
   int             mismatches  = 0;
   int             totals_seen = 0;
   int             sites_sent  = 0;
   int             resizes     = 0;

   lattice_xy_gauge_energy uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // cos(pi * num / den) for num/den up to one half, Q1.14 from a twelve-term Q.28 series
   function automatic logic signed [15:0] series_cos(input longint unsigned num,
                                                     input longint unsigned den);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      int              k;
      x    = (TurnRadQ28 * num + den) / (2 * den);
      x2   = (x * x + (64'd1 << 27)) >> 28;
      term = UnitQ28;
      acc  = $signed(UnitQ28);
      for (k = 1; k <= 12; k++) begin
         term = term * x2 / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return 16'((acc + 64'sd8192) >> 14);
   endfunction

   // Gauge offset for row or column n, radians turned into a 16-bit fraction of a turn
   function automatic logic [15:0] gauge_offset(input int n);
      longint unsigned t;
      t = (64'(n) * RadToTurnQ32 + 64'd32768) >> 16;
      return t[15:0];
   endfunction

   function automatic logic [31:0] bond_cos(input logic [15:0] ang);
      int idx;
      idx = (int'(ang) * TableDepth + 32768) >> 16;
      if (idx >= TableDepth) begin
         idx = idx - TableDepth;
      end
      return 32'(cos_rom[idx]);
   endfunction

   function automatic int side_of(input logic [8:0] v);
      if (v < 9'd2) begin
         return 2;
      end
      if (v > 9'(SideMax)) begin
         return SideMax;
      end
      return int'(v);
   endfunction

   // Sites still needed to close the current frame under the present sizes
   function automatic int sites_to_frame_end();
      int r;
      int c;
      int h;
      int w;
      int n;
      bit done;
      h    = side_of(height_reg);
      w    = side_of(width_reg);
      r    = row_pos;
      c    = (col_pos > SideMax - 1) ? SideMax - 1 : col_pos;
      n    = 0;
      done = 1'b0;
      while (!done) begin
         n++;
         if (c < w - 1) begin
            c++;
         end else if (r < h - 1) begin
            c = 0;
            r++;
         end else begin
            done = 1'b1;
         end
      end
      return n;
   endfunction

   // Add the left and upper bonds of one site; queue the total when the frame closes
   function automatic void predict_site(input logic [15:0] p);
      int          h;
      int          w;
      int          col;
      logic [15:0] d;
      h   = side_of(height_reg);
      w   = side_of(width_reg);
      col = (col_pos > SideMax - 1) ? SideMax - 1 : col_pos;
      if (col > 0) begin
         d = left_site - p + gauge_offset(row_pos);
         energy_acc = energy_acc - bond_cos(d);
      end
      if (row_pos > 0) begin
         d = line_store[col] - p - gauge_offset(col);
         energy_acc = energy_acc - bond_cos(d);
      end
      line_store[col] = p;
      left_site       = p;
      if (col + 1 > cols_seen) begin
         cols_seen = col + 1;
      end
      if (col < w - 1) begin
         col_pos = col + 1;
      end else begin
         col_pos = 0;
         if (row_pos < h - 1) begin
            row_pos++;
         end else begin
            energy_q.push_back(energy_acc);
            energy_acc = '0;
            row_pos    = 0;
         end
      end
   endfunction

   // Uniform phases half the time, with smooth runs, extremes and near quarter turns mixed in
   function automatic logic [15:0] draw_phase(input logic [15:0] prev);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 16'($urandom);
         5, 6: return prev + 16'($urandom_range(0, 600)) - 16'd300;
         7: begin
            case ($urandom_range(0, 3))
               0: return 16'h0000;
               1: return 16'hFFFF;
               2: return 16'h8000;
               default: return 16'h7FFF;
            endcase
         end
         default: return {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [8:0] pick_side();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         return 9'($urandom_range(2, 6));
      end
      if (r < 17) begin
         return 9'($urandom_range(7, 24));
      end
      return 9'($urandom_range(0, 1));
   endfunction

   task automatic push_sites(input int n);
      repeat (n) begin
         last_drawn = draw_phase(last_drawn);
         phase_q.push_back(last_drawn);
      end
   endtask

   // Hold until nothing is queued, in flight or owed, then let the pipeline drain
   task automatic wait_quiet();
      while (phase_q.size() != 0 || req_tvalid || energy_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lxy_pkg::CsrIdxBits-1:0] idx, input logic [8:0] val);
      if (row_pos != 0 || col_pos != 0) begin
         resizes++;
      end
      if (idx == lxy_pkg::CsrGridHeight) begin
         height_reg = val;
      end else begin
         width_reg = val;
      end
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at cycle %0d: %s, energy expected %0d (0x%08h), got %0d (0x%08h)",
                  cycle_count, what, $signed(want), want, $signed(got), got);
      end
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // retire the request taken at this edge
         if (req_tvalid && req_tready) begin
            predict_site(req_tdata);
            sites_sent++;
         end
         // present the next request, or idle with junk on the data lines
         if (!req_tvalid || req_tready) begin
            if (gap_left == 0 && phase_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= phase_q.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 300 : 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
               req_tdata  <= 16'($urandom);
               if (gap_left > 0) begin
                  gap_left--;
               end
            end
         end
      end
   end

   // Response ready: switch between stall patterns over random spans
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (ready_span == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_span = (ready_mode == ReadyHold) ? $urandom_range(5, 60)
                                                   : $urandom_range(10, 300);
         end else begin
            ready_span--;
         end
         case (ready_mode)
            ReadyAlways:   rsp_tready <= 1'b1;
            ReadyCoinFlip: rsp_tready <= 1'($urandom_range(0, 1));
            ReadySparse:   rsp_tready <= ($urandom_range(0, 7) == 0);
            default:       rsp_tready <= 1'b0;
         endcase
      end
   end

   // Check each delivered total against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         totals_seen++;
         if (energy_q.size() == 0) begin
            note_mismatch("total with none owed, expected shown as zero", 32'd0, rsp_tdata);
         end else begin
            expected_total = energy_q.pop_front();
            if (rsp_tdata !== expected_total) begin
               note_mismatch("wrong total", expected_total, rsp_tdata);
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("timeout after %0d cycles, %0d totals still owed", cycle_count, energy_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int         i;
      int         m;
      int         n;
      logic [8:0] v;

      // fill the cosine table over one full turn
      for (i = 0; i < TableDepth; i++) begin
         m = (i <= TableDepth - i) ? i : TableDepth - i;
         if (4 * m > TableDepth) begin
            cos_rom[i] = -series_cos(64'(TableDepth - 2 * m), 64'(TableDepth));
         end else begin
            cos_rom[i] = series_cos(64'(2 * m), 64'(TableDepth));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_quiet();

      // smallest grid reached through under-range sizes, phase extremes
      write_csr(lxy_pkg::CsrGridHeight, 9'd0);
      write_csr(lxy_pkg::CsrGridWidth, 9'd1);
      phase_q.push_back(16'h0000); phase_q.push_back(16'hFFFF);
      phase_q.push_back(16'h8000); phase_q.push_back(16'h4000);
      wait_quiet();

      // in-range minimum, alternating bit patterns
      write_csr(lxy_pkg::CsrGridHeight, 9'd2);
      write_csr(lxy_pkg::CsrGridWidth, 9'd2);
      phase_q.push_back(16'hAAAA); phase_q.push_back(16'h5555);
      phase_q.push_back(16'h5555); phase_q.push_back(16'hAAAA);
      wait_quiet();

      // equal phases everywhere
      repeat (4) phase_q.push_back(16'h8000);
      wait_quiet();

      // 3 x 4 grid; narrow below the current column, then lower below the current row
      write_csr(lxy_pkg::CsrGridHeight, 9'd3);
      write_csr(lxy_pkg::CsrGridWidth, 9'd4);
      phase_q.push_back(16'h1234); phase_q.push_back(16'hFFFF); phase_q.push_back(16'h0001);
      wait_quiet();
      write_csr(lxy_pkg::CsrGridWidth, 9'd2);
      phase_q.push_back(16'h7FFF); phase_q.push_back(16'h8001); phase_q.push_back(16'hC000);
      wait_quiet();
      write_csr(lxy_pkg::CsrGridHeight, 9'd2);
      phase_q.push_back(16'hFFFE); phase_q.push_back(16'h0002);
      wait_quiet();

      // widest and tallest grids through over-range sizes
      write_csr(lxy_pkg::CsrGridHeight, 9'd1);
      write_csr(lxy_pkg::CsrGridWidth, 9'd257);
      push_sites(sites_to_frame_end());
      wait_quiet();
      write_csr(lxy_pkg::CsrGridHeight, 9'd511);
      write_csr(lxy_pkg::CsrGridWidth, 9'd0);
      push_sites(sites_to_frame_end());

      // random sizes, some frames left open so the next sizes land mid-frame
      while (sites_sent < SiteTarget) begin
         wait_quiet();
         if ($urandom_range(0, 9) < 6) begin
            write_csr(lxy_pkg::CsrGridHeight, pick_side());
         end
         if ($urandom_range(0, 9) < 6) begin
            v = pick_side();
            // never widen past columns the line store has seen while below the top row
            if (row_pos == 0 || side_of(v) <= cols_seen) begin
               write_csr(lxy_pkg::CsrGridWidth, v);
            end
         end
         n = sites_to_frame_end();
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, n - 1);
         end
         push_sites(n);
      end

      wait_quiet();
      repeat (DrainCycles) @(posedge clock);
      $display("Streamed %0d sites into %0d energy totals over grid sides 2 to %0d,",
               sites_sent, totals_seen, SideMax);
      $display("with %0d size changes inside a frame and %0d mismatches.", resizes, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
